// ===== src/pcpa_pkg.sv =====
// Package for the per-CPU page allocator: sizes, payload structs and codes.
// Used by every module of the block except pcpa_ram; depends on nothing.
package pcpa_pkg;
    localparam int NUM_CPUS   = 8;
    localparam int MAX_PAGES  = 32768;
    localparam int PAGE_BYTES = 4096;
    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IDX_W  = $clog2(MAX_PAGES + 1);
    localparam int ADDR_W = $clog2(MAX_PAGES);
    localparam int PG_SH  = $clog2(PAGE_BYTES);
    localparam int QDEPTH = 2;
    localparam logic [IDX_W-1:0] NO_PAGE = IDX_W'(MAX_PAGES);
    localparam logic [CPU_W-1:0] LAST_CPU = CPU_W'(NUM_CPUS - 1);

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_PART  = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_INV = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  cpu;
        logic [31:0] addr;
    } req_t;

    typedef struct packed {
        logic [31:0] page_addr;
        logic [1:0]  status;
    } rsp_t;

    // Classified operation passed from front to back.
    typedef struct packed {
        logic             is_free;
        logic             invalid;
        logic [CPU_W-1:0] cpu;
        logic [IDX_W-1:0] idx;
    } op_t;
endpackage

// ===== src/per_cpu_page_free_list_allocator_top.sv =====
// Per-CPU page allocator: a front end that checks and divides, a queue, and a
// back end that owns the lists. A free is answered without a divide when it is
// rejected or the partition size is zero, and after the 32-step partition divide
// otherwise; an allocate examines one list per cycle until it finds a page or has
// examined every list (out of memory). The front takes a new request only after
// passing the last one to the queue; front and back overlap through the queue.
// Reset is synchronous, active low: all lists empty, configuration registers to their defaults;
// the link memory is not cleared.
module per_cpu_page_free_list_allocator_top (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pcpa_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pcpa_pkg::rsp_t  m_data,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    logic [31:0] start_reg, end_reg, part_reg;
    logic          f_valid, f_ready, q_valid, q_ready;
    pcpa_pkg::op_t f_op, q_op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 32'h8000_0000;
            end_reg   <= 32'h8800_0000;
            part_reg  <= 32'h0100_0000;
        end else if (cfg_we) begin
            case (cfg_index)
                pcpa_pkg::CFG_START: start_reg <= cfg_data;
                pcpa_pkg::CFG_END:   end_reg   <= cfg_data;
                pcpa_pkg::CFG_PART:  part_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    pcpa_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_req(s_data), .region_start(start_reg), .region_end(end_reg),
        .partition_bytes(part_reg), .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
    );

    pcpa_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_op(f_op), .rd_valid(q_valid), .rd_ready(q_ready), .rd_op(q_op)
    );

    pcpa_back u_back (
        .aclk(aclk), .aresetn(aresetn), .op_valid(q_valid), .op_ready(q_ready),
        .op(q_op), .region_start(start_reg), .rsp_valid(m_valid),
        .rsp_ready(m_ready), .rsp(m_data)
    );
endmodule

// ===== src/pcpa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No package dependency.
module pcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/pcpa_front.sv =====
// Front end: accepts requests, checks free addresses and computes the owning
// partition with a restoring divider. Depends on pcpa_pkg.
module pcpa_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  pcpa_pkg::req_t   in_req,
    input  logic [31:0]      region_start,
    input  logic [31:0]      region_end,
    input  logic [31:0]      partition_bytes,
    output logic             op_valid,
    input  logic             op_ready,
    output pcpa_pkg::op_t    op
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_OUT  = 3'b100
    } fstate_t;

    fstate_t          state_reg, state_next;
    pcpa_pkg::op_t    op_reg, op_next;
    logic [31:0]      quo_reg, quo_next;
    logic [32:0]      rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;

    logic [32:0] base;
    logic [32:0] off;
    logic [32:0] pidx;
    logic        bad;
    logic [32:0] trial;

    always_comb begin
        base = (33'(region_start) + 33'(pcpa_pkg::PAGE_BYTES - 1))
            >> pcpa_pkg::PG_SH << pcpa_pkg::PG_SH;
        off  = 33'(in_req.addr) - base;
        pidx = off >> pcpa_pkg::PG_SH;
        bad  = (in_req.addr[pcpa_pkg::PG_SH-1:0] != '0) || (in_req.addr < region_start)
            || (in_req.addr >= region_end) || (33'(in_req.addr) < base)
            || (pidx >= 33'(pcpa_pkg::MAX_PAGES));
        trial = {rem_reg[31:0], quo_reg[31]} - 33'(partition_bytes);
    end

    assign in_ready = (state_reg == F_IDLE);
    assign op_valid = (state_reg == F_OUT);
    assign op       = op_reg;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    op_next.is_free = (in_req.cmd == pcpa_pkg::CMD_FREE);
                    op_next.invalid = bad;
                    op_next.cpu     = pcpa_pkg::CPU_W'(in_req.cpu % pcpa_pkg::NUM_CPUS);
                    op_next.idx     = pcpa_pkg::IDX_W'(pidx);
                    quo_next        = in_req.addr - region_start;
                    rem_next        = '0;
                    cnt_next        = '0;
                    if (in_req.cmd == pcpa_pkg::CMD_FREE && !bad && partition_bytes != '0) begin
                        state_next = F_DIV;
                    end else begin
                        op_next.cpu = (in_req.cmd == pcpa_pkg::CMD_FREE) ?
                            pcpa_pkg::LAST_CPU : op_next.cpu;
                        state_next = F_OUT;
                    end
                end
            end
            F_DIV: begin
                if (!trial[32]) begin
                    rem_next = trial;
                    quo_next = {quo_reg[30:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[31:0], quo_reg[31]};
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31) begin
                    op_next.cpu = (quo_next >= 32'(pcpa_pkg::NUM_CPUS)) ? pcpa_pkg::LAST_CPU
                        : pcpa_pkg::CPU_W'(quo_next);
                    state_next = F_OUT;
                end
            end
            F_OUT: begin
                if (op_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg  <= op_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == F_DIV && cnt_reg == 6'd31 |=> state_reg == F_OUT)
        else $error("divider did not finish");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        op_valid && !op_ready |=> op_valid && $stable(op_reg))
        else $error("classified operation changed while stalled");
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        op_valid |-> 32'(op_reg.cpu) < 32'(pcpa_pkg::NUM_CPUS))
        else $error("partition out of range");
endmodule

// ===== src/pcpa_queue.sv =====
// Short queue between front and back ends. Depends on pcpa_pkg.
module pcpa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  pcpa_pkg::op_t  wr_op,
    output logic           rd_valid,
    input  logic           rd_ready,
    output pcpa_pkg::op_t  rd_op
);
    pcpa_pkg::op_t mem [pcpa_pkg::QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'(pcpa_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_op    = mem[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg ^ push;
            rp_reg  <= rp_reg ^ pop;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) begin
            mem[wp_reg] <= wr_op;
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(pcpa_pkg::QDEPTH))
        else $error("queue overflow");
endmodule

// ===== src/pcpa_back.sv =====
// Back end: list heads, link memory, push, pop and steal search.
// Depends on pcpa_pkg and pcpa_ram.
module pcpa_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           op_valid,
    output logic           op_ready,
    input  pcpa_pkg::op_t  op,
    input  logic [31:0]    region_start,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output pcpa_pkg::rsp_t rsp
);
    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_SRCH = 4'b0010,
        B_RD   = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    bstate_t                  state_reg, state_next;
    logic [pcpa_pkg::IDX_W-1:0] head_reg [pcpa_pkg::NUM_CPUS];
    logic [pcpa_pkg::CPU_W-1:0] cur_reg, cur_next;
    logic [6:0]               n_reg, n_next;
    logic [pcpa_pkg::IDX_W-1:0] pg_reg, pg_next;
    pcpa_pkg::rsp_t           rsp_reg, rsp_next;

    logic                         we;
    logic [pcpa_pkg::ADDR_W-1:0]  waddr, raddr;
    logic [pcpa_pkg::IDX_W-1:0]   wdata, rdata;
    logic                         hwe;
    logic [pcpa_pkg::CPU_W-1:0]   hsel;
    logic [pcpa_pkg::IDX_W-1:0]   hval;
    logic [pcpa_pkg::IDX_W-1:0]   h;
    logic [32:0]                  base;

    pcpa_ram #(.WIDTH(pcpa_pkg::IDX_W), .DEPTH(pcpa_pkg::MAX_PAGES)) u_link (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign op_ready  = (state_reg == B_IDLE);
    assign rsp_valid = (state_reg == B_OUT);
    assign rsp       = rsp_reg;
    assign h         = head_reg[cur_reg];
    assign raddr     = h[pcpa_pkg::ADDR_W-1:0];

    always_comb begin
        base       = (33'(region_start) + 33'(pcpa_pkg::PAGE_BYTES - 1))
            >> pcpa_pkg::PG_SH << pcpa_pkg::PG_SH;
        state_next = state_reg;
        cur_next   = cur_reg;
        n_next     = n_reg;
        pg_next    = pg_reg;
        rsp_next   = rsp_reg;
        we         = 1'b0;
        waddr      = op.idx[pcpa_pkg::ADDR_W-1:0];
        wdata      = head_reg[op.cpu];
        hwe        = 1'b0;
        hsel       = cur_reg;
        hval       = rdata;
        case (state_reg)
            B_IDLE: begin
                if (op_valid) begin
                    rsp_next.page_addr = '0;
                    if (op.is_free) begin
                        rsp_next.status = op.invalid ? pcpa_pkg::ST_INV : pcpa_pkg::ST_OK;
                        if (!op.invalid) begin
                            we   = 1'b1;
                            hwe  = 1'b1;
                            hsel = op.cpu;
                            hval = op.idx;
                        end
                        state_next = B_OUT;
                    end else begin
                        cur_next   = op.cpu;
                        n_next     = '0;
                        state_next = B_SRCH;
                    end
                end
            end
            B_SRCH: begin
                if (h != pcpa_pkg::NO_PAGE) begin
                    pg_next    = h;
                    state_next = B_RD;
                end else if (n_reg == 7'(pcpa_pkg::NUM_CPUS - 1)) begin
                    rsp_next.status = pcpa_pkg::ST_OOM;
                    state_next      = B_OUT;
                end else begin
                    cur_next = (cur_reg == pcpa_pkg::LAST_CPU) ? '0 : cur_reg + 1'b1;
                    n_next   = n_reg + 7'd1;
                end
            end
            B_RD: begin
                hwe                = 1'b1;
                rsp_next.status    = pcpa_pkg::ST_OK;
                rsp_next.page_addr = 32'(base + (33'(pg_reg) << pcpa_pkg::PG_SH));
                state_next         = B_OUT;
            end
            B_OUT: begin
                if (rsp_ready) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            for (int i = 0; i < pcpa_pkg::NUM_CPUS; i++) begin
                head_reg[i] <= pcpa_pkg::NO_PAGE;
            end
        end else begin
            state_reg <= state_next;
            if (hwe) begin
                head_reg[hsel] <= hval;
            end
        end
        cur_reg <= cur_next;
        n_reg   <= n_next;
        pg_reg  <= pg_next;
        rsp_reg <= rsp_next;
    end

    a_steal_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_SRCH |-> n_reg < 7'(pcpa_pkg::NUM_CPUS))
        else $error("steal search ran past all lists");
    a_rd_next: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_RD |=> state_reg == B_OUT)
        else $error("pop did not complete");
    a_pop_page: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_RD |-> pg_reg != pcpa_pkg::NO_PAGE)
        else $error("popped an empty list");
endmodule
